@@ rtl/tmm_pkg.sv @@
package tmm_pkg;

  // Default sizing
  localparam int unsigned DepthDef      = 16;
  localparam int unsigned HandleBitsDef = 16;

  // Fixed field widths
  localparam int unsigned TypeW   = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned FillW   = 5;

  // Operation codes
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_TAKE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [TypeW-1:0]   msg_type;
    logic [HandleW-1:0]        msg_handle;
  } tmm_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [TypeW-1:0]   out_type;
    logic [HandleW-1:0]        out_handle;
    logic [FillW-1:0]          fill;
  } tmm_out_t;

endpackage

@@ rtl/typed_message_mailbox.sv @@
// Ordered mailbox of typed messages, up to DEPTH entries in arrival order.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one operation
// per item: push a type and handle at the tail, pop the oldest entry, or take
// the oldest entry whose type matches exactly. Output channel (out_valid_o /
// out_stall_i / out_data_o) returns one result per item: status, the removed
// type and handle (zero if nothing was removed) and the fill count after.
// Entries sit in one RAM used as a ring; a take scans from the oldest entry
// with a single type comparator, one entry per cycle, and closes the gap by
// copying the later entries down one slot, one per cycle through the same
// RAM port pair.
// The block takes one item at a time; in_stall_o is high until the result is
// loaded into the output register. A new item may be accepted while that
// result still waits. If the receiver stalls, the result holds in the output
// register and a following finished result waits inside the block until it is
// taken. Reset empties the mailbox at once; the RAM contents are not cleared.
module typed_message_mailbox
  import tmm_pkg::*;
#(
  parameter int unsigned DEPTH       = DepthDef,
  parameter int unsigned HANDLE_BITS = HandleBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tmm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tmm_out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = TypeW + HANDLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e                   state_q;
  logic [1:0]               kind_q;
  logic signed [TypeW-1:0]  key_q;
  logic [HandleW-1:0]       hdl_q;
  logic [AW-1:0]            head_q;
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            idx_q;
  logic [1:0]               status_q;
  logic signed [TypeW-1:0]  res_type_q;
  logic [HandleW-1:0]       res_hdl_q;
  logic                     out_valid_q;
  tmm_out_t                 out_q;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [WW-1:0]            ram_rdata;
  logic [CW:0]              rd_off;
  logic signed [TypeW-1:0]  rd_type;
  logic [HANDLE_BITS-1:0]   rd_hdl;
  logic                     hit;
  logic [AW-1:0]            head_inc;
  logic                     load_out;

  // Map a position relative to the oldest entry onto a ring slot
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW:0]   off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + off;
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  // Prefetch the next entry to compare or to copy down
  always_comb begin
    unique case (state_q)
      S_SCAN:  rd_off = (CW+1)'(idx_q) + (CW+1)'(1);
      S_SHIFT: rd_off = (CW+1)'(idx_q) + (CW+1)'(2);
      default: rd_off = '0;
    endcase
  end

  assign ram_raddr = slot_of(head_q, rd_off);

  // Write on push, or copy an entry down one slot while closing a gap
  assign ram_we    = (state_q == S_SHIFT) ||
                     ((state_q == S_EXEC) && (kind_q == KIND_PUSH) &&
                      (count_q != CW'(DEPTH)));
  assign ram_waddr = slot_of(head_q, (CW+1)'((state_q == S_SHIFT) ? idx_q : count_q));
  assign ram_wdata = (state_q == S_SHIFT) ? ram_rdata : {key_q, HANDLE_BITS'(hdl_q)};

  tmm_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Shared comparator: pop matches the oldest entry outright
  assign rd_type  = ram_rdata[WW-1 -: TypeW];
  assign rd_hdl   = ram_rdata[HANDLE_BITS-1:0];
  assign hit      = (kind_q == KIND_POP) || (rd_type == key_q);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  // Load the result once the output register is free or being taken
  assign load_out = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= '0;
      key_q       <= '0;
      hdl_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      status_q    <= ST_NONE;
      res_type_q  <= '0;
      res_hdl_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Raise valid on a new result, drop it once the receiver takes it
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= in_data_i.kind;
            key_q   <= in_data_i.msg_type;
            hdl_q   <= in_data_i.msg_handle;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_type_q <= '0;
          res_hdl_q  <= '0;
          idx_q      <= '0;
          unique case (kind_q) inside
            KIND_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_DONE;
                count_q  <= count_q + CW'(1);
              end
              state_q <= S_FINISH;
            end
            KIND_POP, KIND_TAKE: begin
              status_q <= ST_NONE;
              state_q  <= (count_q == '0) ? S_FINISH : S_SCAN;
            end
            default: begin
              status_q <= ST_NONE;
              state_q  <= S_FINISH;
            end
          endcase
        end
        S_SCAN: begin
          if (hit) begin
            res_type_q <= rd_type;
            res_hdl_q  <= HandleW'(rd_hdl);
            status_q   <= ST_DONE;
            if (idx_q == '0) begin
              head_q  <= head_inc;
              count_q <= count_q - CW'(1);
              state_q <= S_FINISH;
            end else if (idx_q + CW'(1) == count_q) begin
              count_q <= count_q - CW'(1);
              state_q <= S_FINISH;
            end else begin
              state_q <= S_SHIFT;
            end
          end else if (idx_q + CW'(1) == count_q) begin
            state_q <= S_FINISH;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_SHIFT: begin
          if (idx_q + CW'(2) == count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_FINISH;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_FINISH: begin
          if (load_out) begin
            out_q.status        <= status_q;
            out_q.out_type      <= res_type_q;
            out_q.out_handle    <= res_hdl_q;
            out_q.fill          <= FillW'(count_q);
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above capacity");

  // The fill count moves by at most one per item
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
    (count_q == $past(count_q) - CW'(1)))
    else $error("fill count jumped");

  // A new result is loaded only from the finishing step
  a_load_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) && (!out_valid_q || !out_stall_i) |=>
    out_valid_q && (state_q == S_IDLE))
    else $error("result not loaded on finish");

  // A rejected push reports a full mailbox
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == ST_FULL) |-> (out_q.fill == FillW'(DEPTH)))
    else $error("full status with room left");

  // Nothing removed means zero type and handle
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ST_DONE) |->
    (out_q.out_type == '0) && (out_q.out_handle == '0))
    else $error("removed fields set without removal");

endmodule

@@ rtl/tmm_ram.sv @@
module tmm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
